### hdl/sha1md_pkg.sv
package sha1md_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        SEL_INPUT,
        SEL_PAD80,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY1,
        PH_MAJORITY,
        PH_PARITY2
    } t_phase;

    typedef struct packed {
        logic      absorb;
        t_byte_sel byte_sel;
        logic      capture_len;
        logic      start_block;
        logic      round;
        t_phase    phase;
        logic      finalize;
        logic      reinit;
        logic [2:0] word_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] pos;
    } t_dp_status;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] POS_LAST = 6'd63;
    localparam logic [5:0] POS_LEN  = 6'd56;

    localparam logic [6:0] ROUND_PH1  = 7'd20;
    localparam logic [6:0] ROUND_PH2  = 7'd40;
    localparam logic [6:0] ROUND_PH3  = 7'd60;
    localparam logic [6:0] ROUND_LAST = 7'd79;

    localparam logic [2:0] WORD_LAST = 3'd4;

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = H0_INIT;
            3'd1:    v = H1_INIT;
            3'd2:    v = H2_INIT;
            3'd3:    v = H3_INIT;
            default: v = H4_INIT;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input t_phase ph);
        logic [31:0] v;
        case (ph)
            PH_CHOOSE:   v = 32'h5A827999;
            PH_PARITY1:  v = 32'h6ED9EBA1;
            PH_MAJORITY: v = 32'h8F1BBCDC;
            default:     v = 32'hCA62C1D6;
        endcase
        return v;
    endfunction

endpackage

### hdl/sha1_message_digest.sv
// Streaming SHA-1 engine.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one transaction per
// message byte. A transaction with end_of_message set closes the message
// after its byte, if byte_present is set; with byte_present clear it carries
// no byte, so an empty message is one transaction with only the end mark.
//
// Output channel (o_out_valid / i_out_ready / o_out_data): after the end mark
// the engine pads the message and sends five transactions, digest words H0
// through H4 in order, with last_word set on the fifth.
//
// Throughput: bytes are taken back to back while the engine is idle. Every
// 64th byte starts a block compression: 80 rounds of the single round unit,
// one round per cycle, followed by the chaining update. After the end mark
// the engine pads the message and runs one or two compressions before the
// first digest word. Input is not accepted while a block is compressed,
// during padding, or until the fifth digest word is taken.
//
// Reset loads the SHA-1 initial chaining values and clears the bit count.
// A stalled receiver simply holds the current word; nothing is dropped.
module sha1_message_digest (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sha1md_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sha1md_pkg::t_out_item o_out_data
);

    sha1md_pkg::t_dp_cmd    cmd;
    sha1md_pkg::t_dp_status status;
    logic [31:0]            word;
    logic [2:0]             word_index;
    logic                   last_word;

    // The controller sequences byte intake, padding, rounds and readout.
    sha1md_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_byte_present   (i_in_data.byte_present),
        .i_end_of_message (i_in_data.end_of_message),
        .o_in_ready       (o_in_ready),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_word_index     (word_index),
        .o_last_word      (last_word),
        .i_status         (status),
        .o_cmd            (cmd)
    );

    // The datapath holds the message window, working and chaining words.
    sha1md_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_byte   (i_in_data.data_byte),
        .o_status (status),
        .o_word   (word)
    );

    assign o_out_data.digest_word = word;
    assign o_out_data.word_index  = word_index;
    assign o_out_data.last_word   = last_word;

`ifndef NO_ASSERTIONS
    // Input intake and digest readout never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a digest word is offered");

    // A taken word that is not the last is followed by the next word.
    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last_word) |=>
        (o_out_valid && (o_out_data.word_index == $past(o_out_data.word_index) + 3'd1)))
        else $error("digest words out of sequence");

    // After the last word is taken the engine is ready for a new message.
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_word) |=> o_in_ready)
        else $error("engine not ready after digest");

    // The last word flag marks exactly the fifth word.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_word == (o_out_data.word_index == 3'd4)))
        else $error("last_word does not match word_index");
`endif

endmodule

### hdl/sha1md_datapath.sv
module sha1md_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sha1md_pkg::t_dp_cmd    i_cmd,
    input  logic [7:0]             i_byte,
    output sha1md_pkg::t_dp_status o_status,
    output logic [31:0]            o_word
);

    // Message window: 64 bytes while filling, then the 16-word schedule.
    logic [31:0] r_win [16];
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [63:0] r_count;
    logic [63:0] r_len;

    logic [63:0] n_count;
    logic [63:0] len_sh;
    logic [7:0]  sel_byte;
    logic [31:0] f_val;
    logic [31:0] sched_new;
    logic [31:0] tmp;
    logic [5:0]  pos;

    assign pos             = r_count[8:3];
    assign o_status.pos    = pos;
    assign n_count         = i_cmd.absorb ? (r_count + 64'd8) : r_count;
    assign len_sh          = r_len >> {~pos[2:0], 3'b000};
    assign o_word          = r_h[i_cmd.word_sel];

    always_comb begin
        case (i_cmd.byte_sel)
            sha1md_pkg::SEL_INPUT: sel_byte = i_byte;
            sha1md_pkg::SEL_PAD80: sel_byte = sha1md_pkg::PAD_BYTE;
            sha1md_pkg::SEL_LEN:   sel_byte = len_sh[7:0];
            default:               sel_byte = 8'h00;
        endcase
    end

    always_comb begin
        case (i_cmd.phase)
            sha1md_pkg::PH_CHOOSE:   f_val = (r_b & r_c) | (~r_b & r_d);
            sha1md_pkg::PH_MAJORITY: f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            default:                 f_val = r_b ^ r_c ^ r_d;
        endcase
    end

    always_comb begin
        logic [31:0] x;
        x         = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        sched_new = {x[30:0], x[31]};
        tmp       = {r_a[26:0], r_a[31:27]} + f_val + r_e
                    + sha1md_pkg::round_k(i_cmd.phase) + r_win[0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= {r_win[i][23:0], r_win[i+1][31:24]};
            end
            r_win[15] <= {r_win[15][23:0], sel_byte};
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= sched_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_len) begin
            r_len <= n_count;
        end
        if (i_cmd.start_block) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round) begin
            r_a <= tmp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= sha1md_pkg::init_word(3'(i));
            end
            r_count <= 64'd0;
        end else begin
            r_count <= n_count;
            if (i_cmd.finalize) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
        end
    end

endmodule

### hdl/sha1md_ctrl.sv
module sha1md_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_byte_present,
    input  logic                   i_end_of_message,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_word_index,
    output logic                   o_last_word,
    input  sha1md_pkg::t_dp_status i_status,
    output sha1md_pkg::t_dp_cmd    o_cmd
);

    sha1md_pkg::t_state    r_state, n_state;
    logic [6:0]            r_round, n_round;
    logic [2:0]            r_idx, n_idx;
    logic                  r_first, n_first;
    logic                  r_wrap, n_wrap;
    logic                  r_pend, n_pend;
    logic                  r_out_next, n_out_next;
    sha1md_pkg::t_byte_sel pad_sel;
    logic                  at_last;
    logic                  in_len_zone;

    assign at_last     = (i_status.pos == sha1md_pkg::POS_LAST);
    assign in_len_zone = (i_status.pos >= sha1md_pkg::POS_LEN);

    // Padding byte: 0x80 first, then zeros, then the length bytes at 56..63
    // of the final block.
    always_comb begin
        if (r_first) begin
            pad_sel = sha1md_pkg::SEL_PAD80;
        end else if (!r_wrap && in_len_zone) begin
            pad_sel = sha1md_pkg::SEL_LEN;
        end else begin
            pad_sel = sha1md_pkg::SEL_ZERO;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_round    = r_round;
        n_idx      = r_idx;
        n_first    = r_first;
        n_wrap     = r_wrap;
        n_pend     = r_pend;
        n_out_next = r_out_next;
        case (r_state)
            sha1md_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_end_of_message) begin
                        n_pend  = 1'b1;
                        n_first = 1'b1;
                        n_wrap  = 1'b0;
                    end
                    if (i_byte_present && at_last) begin
                        n_state = sha1md_pkg::ST_ROUND;
                        n_round = 7'd0;
                    end else if (i_end_of_message) begin
                        n_state = sha1md_pkg::ST_PAD;
                    end
                end
            end
            sha1md_pkg::ST_PAD: begin
                n_first = 1'b0;
                if (at_last) begin
                    n_wrap     = 1'b0;
                    n_out_next = (pad_sel == sha1md_pkg::SEL_LEN);
                    n_state    = sha1md_pkg::ST_ROUND;
                    n_round    = 7'd0;
                end else if (r_first && in_len_zone) begin
                    n_wrap = 1'b1;
                end
            end
            sha1md_pkg::ST_ROUND: begin
                n_round = r_round + 7'd1;
                if (r_round == sha1md_pkg::ROUND_LAST) begin
                    n_state = sha1md_pkg::ST_FINAL;
                end
            end
            sha1md_pkg::ST_FINAL: begin
                if (r_out_next) begin
                    n_state    = sha1md_pkg::ST_OUT;
                    n_idx      = 3'd0;
                    n_pend     = 1'b0;
                    n_out_next = 1'b0;
                end else if (r_pend) begin
                    n_state = sha1md_pkg::ST_PAD;
                end else begin
                    n_state = sha1md_pkg::ST_IDLE;
                end
            end
            sha1md_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == sha1md_pkg::WORD_LAST) begin
                        n_state = sha1md_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = sha1md_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.word_sel = r_idx;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_word_index = r_idx;
        o_last_word  = (r_idx == sha1md_pkg::WORD_LAST);
        if (r_round < sha1md_pkg::ROUND_PH1) begin
            o_cmd.phase = sha1md_pkg::PH_CHOOSE;
        end else if (r_round < sha1md_pkg::ROUND_PH2) begin
            o_cmd.phase = sha1md_pkg::PH_PARITY1;
        end else if (r_round < sha1md_pkg::ROUND_PH3) begin
            o_cmd.phase = sha1md_pkg::PH_MAJORITY;
        end else begin
            o_cmd.phase = sha1md_pkg::PH_PARITY2;
        end
        case (r_state)
            sha1md_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.byte_sel = sha1md_pkg::SEL_INPUT;
                if (i_in_valid) begin
                    o_cmd.absorb      = i_byte_present;
                    o_cmd.capture_len = i_end_of_message;
                    o_cmd.start_block = i_byte_present && at_last;
                end
            end
            sha1md_pkg::ST_PAD: begin
                o_cmd.absorb      = 1'b1;
                o_cmd.byte_sel    = pad_sel;
                o_cmd.start_block = at_last;
            end
            sha1md_pkg::ST_ROUND: begin
                o_cmd.round = 1'b1;
            end
            sha1md_pkg::ST_FINAL: begin
                o_cmd.finalize = 1'b1;
            end
            sha1md_pkg::ST_OUT: begin
                o_out_valid  = 1'b1;
                o_cmd.reinit = i_out_ready && (r_idx == sha1md_pkg::WORD_LAST);
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha1md_pkg::ST_IDLE;
            r_round    <= 7'd0;
            r_idx      <= 3'd0;
            r_first    <= 1'b0;
            r_wrap     <= 1'b0;
            r_pend     <= 1'b0;
            r_out_next <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_round    <= n_round;
            r_idx      <= n_idx;
            r_first    <= n_first;
            r_wrap     <= n_wrap;
            r_pend     <= n_pend;
            r_out_next <= n_out_next;
        end
    end

endmodule

### tb/tb_sha1_message_digest.sv
module tb_sha1_message_digest;
    timeunit 1ns;
    timeprecision 1ps;

    // Only the first few mismatches are printed; the rest are just counted.
    localparam int MAX_REPORTED = 10;
    // The quiet time after the last word outlasts the engine's path from an
    // end mark to its first digest word, so it is generous.
    localparam int DRAIN_CYCLES = 300;
    localparam int DRAIN_GUARD  = 5000;

    // SHA-1 initial chaining values and round constants.
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] IV_E = 32'hC3D2E1F0;

    localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
    localparam logic [31:0] K_PARITY_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
    localparam logic [31:0] K_PARITY_2 = 32'hCA62C1D6;

    // Padding: one marker byte, zeros up to byte 56, then the bit length.
    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [7:0] PAD_FILL      = 8'h00;
    localparam logic [5:0] LENGTH_POS    = 6'd56;
    localparam logic [5:0] BLOCK_END_POS = 6'd63;
    localparam int         DIGEST_WORDS  = 5;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    sha1md_pkg::t_in_item  in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    sha1md_pkg::t_out_item out_item;

    // Percent of cycles in which the sender holds back and the receiver stalls.
    int idle_pct  = 21;
    int stall_pct = 21;
    int mismatches = 0;

    // Predictor state: chaining words, the block being filled, the bit count
    // of the current message, and the digest words still to arrive.
    logic [31:0]           hash_state [DIGEST_WORDS];
    logic [7:0]            block_bytes [64];
    logic [63:0]           msg_bits;
    sha1md_pkg::t_out_item expected_words [$];

    sha1_message_digest u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Start of a new message: initial chaining values and a zero bit count.
    // The block buffer is never read before all 64 bytes have been written.
    function automatic void restart_hash();
        hash_state[0] = IV_A;
        hash_state[1] = IV_B;
        hash_state[2] = IV_C;
        hash_state[3] = IV_D;
        hash_state[4] = IV_E;
        msg_bits = '0;
    endfunction

    // One 80-round SHA-1 compression of the full block into the chaining words.
    // The whole schedule is expanded up front rather than kept in a window.
    function automatic void compress_block_bytes();
        logic [31:0] sched [80];
        logic [31:0] a, b, c, d, e, f, k, mix;
        int          t;
        for (t = 0; t < 16; t++) begin
            sched[t] = {block_bytes[4*t], block_bytes[4*t+1],
                        block_bytes[4*t+2], block_bytes[4*t+3]};
        end
        for (t = 16; t < 80; t++) begin
            mix = sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16];
            sched[t] = {mix[30:0], mix[31]};
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_CHOOSE;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_PARITY_1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJORITY;
            end else begin
                f = b ^ c ^ d;
                k = K_PARITY_2;
            end
            mix = {a[26:0], a[31:27]} + f + e + k + sched[t];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = mix;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // Places one byte at the current block position; the 64th byte of a
    // block triggers its compression.
    function automatic void absorb_byte(input logic [7:0] value);
        logic [5:0] pos;
        pos = msg_bits[8:3];
        block_bytes[pos] = value;
        msg_bits += 64'd8;
        if (pos == BLOCK_END_POS) begin
            compress_block_bytes();
        end
    endfunction

    // Applies one accepted transaction to the predictor. An end mark pads the
    // message, queues the five digest words and starts over.
    function automatic void predict_digest(input sha1md_pkg::t_in_item item);
        logic [63:0]           length_bits;
        sha1md_pkg::t_out_item word;
        int                    i;
        if (item.byte_present) begin
            absorb_byte(item.data_byte);
        end
        if (!item.end_of_message) begin
            return;
        end
        length_bits = msg_bits;
        absorb_byte(PAD_MARK);
        while (msg_bits[8:3] != LENGTH_POS) begin
            absorb_byte(PAD_FILL);
        end
        for (i = 0; i < 8; i++) begin
            absorb_byte(length_bits[63 - 8*i -: 8]);
        end
        for (i = 0; i < DIGEST_WORDS; i++) begin
            word.digest_word = hash_state[i];
            word.word_index  = 3'(i);
            word.last_word   = (3'(i) == sha1md_pkg::WORD_LAST);
            expected_words.push_back(word);
        end
        restart_hash();
    endfunction

    // Compares one received digest word, field by field, with the oldest
    // expectation. A word that nobody expects is a failure as well.
    function automatic void check_digest_word(input sha1md_pkg::t_out_item got);
        sha1md_pkg::t_out_item want;
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
                $display("unexpected digest word: word %h index %0d last %0b",
                         got.digest_word, got.word_index, got.last_word);
            end
            return;
        end
        want = expected_words.pop_front();
        if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
            got.last_word !== want.last_word) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
                $display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                         want.digest_word, want.word_index, want.last_word,
                         got.digest_word, got.word_index, got.last_word);
            end
        end
    endfunction

    // Output side: a word is taken at an edge where valid and ready are both
    // high. The ready seen here is the one the engine saw at this edge; the
    // next value is scheduled after the check.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            check_digest_word(out_item);
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic sha1md_pkg::t_in_item make_item(input logic [7:0] data,
                                                       input logic present,
                                                       input logic finish);
        sha1md_pkg::t_in_item item;
        item.data_byte      = data;
        item.byte_present   = present;
        item.end_of_message = finish;
        return item;
    endfunction

    // Sends one transaction. Valid is dropped only for sender idle cycles and
    // otherwise stays high from one transaction into the next, so each time
    // step sees at most one assignment to it. Returns at the accepting edge.
    task automatic send_transaction(input sha1md_pkg::t_in_item item);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        predict_digest(item);
    endtask

    // Sends a message of random bytes. The end mark either rides on the last
    // byte or comes as a separate transaction without a byte. Transactions
    // with neither byte nor end mark are mixed in as noise.
    task automatic send_message(input int len, input bit end_on_byte, input int noise_pct);
        int i;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                send_transaction(make_item(8'($urandom), 1'b0, 1'b0));
            end
            send_transaction(make_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1)));
        end
        if (!end_on_byte || len == 0) begin
            send_transaction(make_item(8'($urandom), 1'b0, 1'b1));
        end
    endtask

    // Short hand-picked messages: the empty message, "abc" closed both ways,
    // all-zero and all-one bytes, an ignored transaction inside a message,
    // and data bytes that must be ignored when no byte is present.
    task automatic test_directed();
        idle_pct  = 21;
        stall_pct = 21;
        send_transaction(make_item(8'hFF, 1'b0, 1'b1));
        send_transaction(make_item(8'h61, 1'b1, 1'b0));
        send_transaction(make_item(8'h62, 1'b1, 1'b0));
        send_transaction(make_item(8'h63, 1'b1, 1'b1));
        send_transaction(make_item(8'h61, 1'b1, 1'b0));
        send_transaction(make_item(8'h62, 1'b1, 1'b0));
        send_transaction(make_item(8'h63, 1'b1, 1'b0));
        send_transaction(make_item(8'h5A, 1'b0, 1'b1));
        send_transaction(make_item(8'hC3, 1'b0, 1'b0));
        send_transaction(make_item(8'h00, 1'b1, 1'b0));
        send_transaction(make_item(8'hA5, 1'b0, 1'b0));
        send_transaction(make_item(8'hFF, 1'b1, 1'b1));
        send_transaction(make_item(8'h00, 1'b1, 1'b1));
        send_transaction(make_item(8'hFF, 1'b1, 1'b0));
        send_transaction(make_item(8'h00, 1'b0, 1'b1));
    endtask

    // A 56-byte message puts the marker byte at position 56, too late for the
    // length field, so the padding spills into a second block. Run with no
    // idling at all on either side, so the engine sees back-to-back traffic
    // for a long stretch.
    task automatic test_padding_boundaries();
        idle_pct  = 0;
        stall_pct = 0;
        send_message(56, 1'b1, 0);
    endtask

    // Random short messages with random end style and some noise transactions.
    task automatic test_random_messages();
        int sent_bytes;
        int messages;
        int len;
        idle_pct   = 21;
        stall_pct  = 21;
        sent_bytes = 0;
        messages   = 0;
        while ((sent_bytes < 40 || messages < 6) && messages < 20) begin
            len = $urandom_range(12);
            send_message(len, 1'($urandom_range(1)), 10);
            sent_bytes += len;
            messages++;
        end
    endtask

    initial begin
        int guard;
        restart_hash();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_padding_boundaries();
        test_random_messages();

        // All stimulus is in; let the last digest drain, then stay a while
        // longer so a stray extra word would still be caught.
        in_valid <= 1'b0;
        guard = 0;
        while (expected_words.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("tb_sha1_message_digest: done, clean");
        end else begin
            $display("tb_sha1_message_digest: done, errors");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #5ms;
        $display("tb_sha1_message_digest: done, errors");
        $finish;
    end

endmodule
